/* hw/rtl/shdm_pkg.sv */
// Shared types and constants for the string hashed direct map.
// Used by shdm_rem_unit, string_hashed_direct_map and the testbench; depends on nothing.
`default_nettype none

package shdm_pkg;

  localparam int TABLE_DEPTH_DEF = 256;
  localparam int HANDLE_BITS_DEF = 32;

  localparam int HASH_MUL = 71;
  localparam int POS_MUL  = 37;

  localparam int CFG_W        = 9;
  localparam int CHAR_W       = 8;
  localparam int HANDLE_W     = 32;
  localparam int SLOT_W       = 8;
  localparam int DIVIDEND_W   = 16;
  localparam int STEP_W       = 5;
  localparam int SIZE_RESET   = 256;
  localparam int SIZE_LIMIT   = 511;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_FIND   = 1'b1;

  typedef struct packed {
    logic                mode;
    logic [CHAR_W-1:0]   key_char;
    logic                key_last;
    logic [HANDLE_W-1:0] handle;
  } in_item_t;

  typedef struct packed {
    logic                found;
    logic [HANDLE_W-1:0] slot_handle_out;
    logic [SLOT_W-1:0]   slot_index;
  } out_item_t;

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
  } rem_req_t;

endpackage

`default_nettype wire

/* hw/rtl/shdm_rem_unit.sv */
// Restoring remainder unit, one quotient bit per cycle, MSB first.
// Depends on shdm_pkg for the request struct and dividend width.
`default_nettype none

module shdm_rem_unit #(
  parameter int DIVISOR_BITS = 9
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire shdm_pkg::rem_req_t                req_i,
  input  wire logic [shdm_pkg::DIVIDEND_W-1:0]   dividend_i,
  input  wire logic [DIVISOR_BITS-1:0]           divisor_i,
  output logic [DIVISOR_BITS-1:0]                rem_o,
  output logic                                   done_o
);

  localparam int DW = shdm_pkg::DIVIDEND_W;

  logic [shdm_pkg::STEP_W-1:0] cnt_d, cnt_q;
  logic [DIVISOR_BITS-1:0]     rem_d, rem_q;
  logic [DW-1:0]               dvd_d, dvd_q;
  logic [DIVISOR_BITS:0]       trial;
  logic [DIVISOR_BITS:0]       diff;
  logic                        fits;

  assign trial = {rem_q, dvd_q[DW-1]};
  assign diff  = trial - {1'b0, divisor_i};
  assign fits  = trial >= {1'b0, divisor_i};

  always_comb begin
    cnt_d = cnt_q;
    rem_d = rem_q;
    dvd_d = dvd_q;
    if (req_i.start) begin
      cnt_d = req_i.steps;
      rem_d = '0;
      dvd_d = dividend_i;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
      rem_d = fits ? diff[DIVISOR_BITS-1:0] : trial[DIVISOR_BITS-1:0];
      dvd_d = {dvd_q[DW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
  end

  assign rem_o  = rem_q;
  assign done_o = (cnt_q == '0);

endmodule

`default_nettype wire

/* hw/rtl/string_hashed_direct_map.sv */
// Top level of the string hashed direct map: hash sequencer, slot memory, output register.
// Depends on shdm_pkg and shdm_rem_unit.
//
//   channel  direction  transfer when            payload
//   in       sink       in_valid_i & !in_stall_o  shdm_pkg::in_item_t
//   out      source     out_valid_o & !out_stall_i shdm_pkg::out_item_t
//   cfg      sink       cfg_we_i                  table_size, 9 bits
//
// After its transfer a character keeps the input stalled through the load, hash and
// position states, the last character through the done state too; HW is the hash width
// (8 at the default depth). The shared remainder unit runs 16 steps for the hash and
// HW + 1 for the position. After reset a clearing pass empties every slot of the slot
// memory; no input is taken meanwhile. A stalled result waits in the output register
// while the next key is hashed; only loading the next result waits for it.
`default_nettype none

module string_hashed_direct_map #(
  parameter int TABLE_DEPTH = shdm_pkg::TABLE_DEPTH_DEF,
  parameter int HANDLE_BITS = shdm_pkg::HANDLE_BITS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire shdm_pkg::in_item_t             in_data_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output shdm_pkg::out_item_t                 out_data_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [shdm_pkg::CFG_W-1:0]     cfg_wdata_i
);

  localparam int SIZE_MAX = (TABLE_DEPTH < shdm_pkg::SIZE_LIMIT) ? TABLE_DEPTH
                                                                 : shdm_pkg::SIZE_LIMIT;
  localparam int HW       = $clog2(SIZE_MAX);
  localparam int DVW      = $clog2(SIZE_MAX + 1);
  localparam int IDX_W    = $clog2(TABLE_DEPTH);
  localparam int DW       = shdm_pkg::DIVIDEND_W;
  localparam int CW       = shdm_pkg::CFG_W;
  localparam int OW       = shdm_pkg::HANDLE_W;
  localparam int SW       = shdm_pkg::SLOT_W;

  typedef enum logic [5:0] {
    StClear = 6'b000001,
    StIdle  = 6'b000010,
    StLoad  = 6'b000100,
    StHash  = 6'b001000,
    StPos   = 6'b010000,
    StDone  = 6'b100000
  } state_e;

  state_e                 state_d, state_q;
  logic [HW-1:0]          hash_d, hash_q;
  logic [HW-1:0]          pos_d, pos_q;
  logic [HW-1:0]          slot_d, slot_q;
  logic [IDX_W-1:0]       clr_d, clr_q;
  logic [CW-1:0]          tsize_q;
  shdm_pkg::in_item_t     item_q;

  logic                   out_valid_d, out_valid_q;
  shdm_pkg::out_item_t    out_data_d, out_data_q;
  logic                   out_free;
  logic                   out_load;

  logic [CW-1:0]          size_clamp;
  logic [DVW-1:0]         size_use;

  shdm_pkg::rem_req_t     rem_req;
  logic [DW-1:0]          rem_dividend;
  logic [DVW-1:0]         rem_val;
  logic                   rem_done;

  logic [DW-1:0]          mix;
  logic [HW:0]            pos_inc;
  logic [DW-1:0]          pos_dividend;

  logic [HANDLE_BITS:0]   mem_q [TABLE_DEPTH];
  logic [HANDLE_BITS:0]   rd_q;
  logic                   mem_we;
  logic                   mem_re;
  logic [IDX_W-1:0]       mem_addr;
  logic [HANDLE_BITS:0]   mem_wdata;

  logic [HANDLE_BITS+OW-1:0] hin_wide;
  logic [HANDLE_BITS-1:0]    hin;
  logic [HANDLE_BITS-1:0]    hsel;
  logic [HANDLE_BITS+OW-1:0] hout_wide;
  logic [HW+SW-1:0]          slot_wide;

  always_comb begin
    size_clamp = tsize_q;
    if (tsize_q == '0) begin
      size_clamp = CW'(1);
    end else if (tsize_q > CW'(SIZE_MAX)) begin
      size_clamp = CW'(SIZE_MAX);
    end
  end
  assign size_use = size_clamp[DVW-1:0];

  assign mix = DW'(hash_q) * DW'(shdm_pkg::HASH_MUL)
             + DW'(pos_q) * DW'(shdm_pkg::POS_MUL)
             + DW'(item_q.key_char);
  assign pos_inc      = {1'b0, pos_q} + 1'b1;
  assign pos_dividend = {pos_inc, {(DW-HW-1){1'b0}}};

  assign hin_wide  = (HANDLE_BITS+OW)'(item_q.handle);
  assign hin       = hin_wide[HANDLE_BITS-1:0];
  assign hsel      = (item_q.mode == shdm_pkg::MODE_INSERT) ? hin
                   : (rd_q[HANDLE_BITS] ? rd_q[HANDLE_BITS-1:0] : '0);
  assign hout_wide = (HANDLE_BITS+OW)'(hsel);
  assign slot_wide = (HW+SW)'(slot_q);

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d      = state_q;
    hash_d       = hash_q;
    pos_d        = pos_q;
    slot_d       = slot_q;
    clr_d        = clr_q;
    rem_req      = '0;
    rem_dividend = mix;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_addr     = IDX_W'(slot_q);
    mem_wdata    = {1'b1, hin};
    out_load     = 1'b0;
    unique case (state_q)
      StClear: begin
        mem_we    = 1'b1;
        mem_addr  = clr_q;
        mem_wdata = '0;
        clr_d     = clr_q + 1'b1;
        if (clr_q == IDX_W'(TABLE_DEPTH - 1)) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (in_valid_i) begin
          state_d = StLoad;
        end
      end
      StLoad: begin
        rem_req.start = 1'b1;
        rem_req.steps = shdm_pkg::STEP_W'(DW);
        state_d       = StHash;
      end
      StHash: begin
        if (rem_done) begin
          slot_d        = rem_val[HW-1:0];
          rem_req.start = 1'b1;
          rem_req.steps = shdm_pkg::STEP_W'(HW + 1);
          rem_dividend  = pos_dividend;
          state_d       = StPos;
        end
      end
      StPos: begin
        if (rem_done) begin
          if (item_q.key_last) begin
            hash_d  = '0;
            pos_d   = '0;
            mem_we  = (item_q.mode == shdm_pkg::MODE_INSERT);
            mem_re  = (item_q.mode == shdm_pkg::MODE_FIND);
            state_d = StDone;
          end else begin
            hash_d  = slot_q;
            pos_d   = rem_val[HW-1:0];
            state_d = StIdle;
          end
        end
      end
      StDone: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  assign in_stall_o = (state_q != StIdle);

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (out_load) begin
      out_valid_d                = 1'b1;
      out_data_d.found           = (item_q.mode == shdm_pkg::MODE_INSERT) | rd_q[HANDLE_BITS];
      out_data_d.slot_handle_out = hout_wide[OW-1:0];
      out_data_d.slot_index      = slot_wide[SW-1:0];
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  shdm_rem_unit #(
    .DIVISOR_BITS(DVW)
  ) u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (rem_req),
    .dividend_i (rem_dividend),
    .divisor_i  (size_use),
    .rem_o      (rem_val),
    .done_o     (rem_done)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      hash_q      <= '0;
      pos_q       <= '0;
      clr_q       <= '0;
      tsize_q     <= CW'(shdm_pkg::SIZE_RESET);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      hash_q      <= hash_d;
      pos_q       <= pos_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        tsize_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q     <= slot_d;
    out_data_q <= out_data_d;
    if (in_valid_i && !in_stall_o) begin
      item_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem_q[mem_addr];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

/* tb/shdm_result_checker.sv */
`timescale 1ns / 100ps
// Result checker for string_hashed_direct_map: watches the in, out and cfg ports,
// predicts each lookup result and compares it with what the block returns.
// Depends on shdm_pkg for the payload types, mode codes and hash constants.

module shdm_result_checker
  import shdm_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  in_item_t             in_data_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  out_item_t            out_data_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  output int                   mismatch_count_o,
  output int                   pending_count_o
);

  logic [CFG_W-1:0]    table_size;
  int                  run_hash;
  int                  run_pos;
  logic                slot_full [TABLE_DEPTH_DEF];
  logic [HANDLE_W-1:0] slot_handle [TABLE_DEPTH_DEF];
  out_item_t           lookups_due [$];
  int                  errs;

  function automatic int modulus_of(input logic [CFG_W-1:0] cfg);
    if (cfg == '0) return 1;
    if (cfg > TABLE_DEPTH_DEF) return TABLE_DEPTH_DEF;
    return int'(cfg);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    int        size;
    int        h;
    int        p;
    out_item_t want;
    out_item_t got;
    if (!rst_ni) begin
      table_size = CFG_W'(SIZE_RESET);
      run_hash   = 0;
      run_pos    = 0;
      for (int i = 0; i < TABLE_DEPTH_DEF; i++) slot_full[i] = 1'b0;
      lookups_due.delete();
      errs = 0;
    end else begin
      if ($isunknown(out_valid_i)) begin
        $display("%0t: out valid unknown: expected 0 or 1, actual %b", $time, out_valid_i);
        errs++;
      end else if (out_valid_i && out_stall_i === 1'b0) begin
        got = out_data_i;
        if (lookups_due.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual found=%b handle=%h slot=%h",
                   $time, got.found, got.slot_handle_out, got.slot_index);
          errs++;
        end else begin
          want = lookups_due.pop_front();
          if (got.found !== want.found || got.slot_handle_out !== want.slot_handle_out ||
              got.slot_index !== want.slot_index) begin
            $display("%0t: result mismatch: expected found=%b handle=%h slot=%h, %s%b %s%h %s%h",
                     $time, want.found, want.slot_handle_out, want.slot_index,
                     "actual found=", got.found, "handle=", got.slot_handle_out,
                     "slot=", got.slot_index);
            errs++;
          end
        end
      end

      if (in_valid_i === 1'b1 && in_stall_i === 1'b0) begin
        size = modulus_of(table_size);
        h    = run_hash % size;
        p    = run_pos % size;
        h    = (h * HASH_MUL + int'(in_data_i.key_char) + POS_MUL * p) % size;
        p    = (p + 1) % size;
        if (!in_data_i.key_last) begin
          run_hash = h;
          run_pos  = p;
        end else begin
          run_hash = 0;
          run_pos  = 0;
          if (in_data_i.mode == MODE_INSERT) begin
            slot_handle[h] = in_data_i.handle;
            slot_full[h]   = 1'b1;
          end
          want.found           = slot_full[h];
          want.slot_handle_out = slot_full[h] ? slot_handle[h] : '0;
          want.slot_index      = h[SLOT_W-1:0];
          lookups_due.push_back(want);
        end
      end

      if (cfg_we_i) table_size = cfg_wdata_i;
    end
    mismatch_count_o <= errs;
    pending_count_o  <= lookups_due.size();
  end

endmodule

/* tb/tb_string_hashed_direct_map.sv */
`timescale 1ns / 100ps
// Testbench top for string_hashed_direct_map: drives keys one character per transfer,
// changes the table size between phases and gives the verdict.
// Depends on shdm_pkg, the block and shdm_result_checker.

module tb_string_hashed_direct_map;
  import shdm_pkg::*;

  localparam int ITEM_TARGET   = 1350;
  localparam int SETTLE_CYCLES = 80;
  localparam int MAX_KEY_LEN   = 6;
  localparam int IN_W          = $bits(in_item_t);

  typedef struct packed {
    logic [2:0]                   len;
    logic [MAX_KEY_LEN-1:0][7:0]  chars;
  } key_t;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             in_valid_i  = 1'b0;
  logic             in_stall_o;
  in_item_t         in_data_i   = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  out_item_t        out_data_o;
  logic             cfg_we_i    = 1'b0;
  logic [CFG_W-1:0] cfg_wdata_i = '0;
  int               mismatch_count;
  int               pending_count;

  int   chars_sent = 0;
  int   burst_left = 0;
  int   stall_mode = 0;
  int   stall_left = 0;
  int   run_left   = 0;
  key_t key_pool [$];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  string_hashed_direct_map i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  shdm_result_checker i_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .in_data_i        (in_data_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_data_i       (out_data_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .mismatch_count_o (mismatch_count),
    .pending_count_o  (pending_count)
  );

  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 200);
    end
    stall_left--;
    case (stall_mode)
      0: out_stall_i = 1'b0;
      1: out_stall_i = ($urandom_range(0, 3) == 0);
      2: out_stall_i = ($urandom_range(0, 3) != 0);
      default: begin
        if (run_left == 0) begin
          out_stall_i = !out_stall_i;
          run_left    = out_stall_i ? $urandom_range(5, 20) : $urandom_range(1, 4);
        end
        run_left--;
      end
    endcase
  end

  task automatic send_char(input logic mode, input logic [7:0] ch, input logic last,
                           input logic [HANDLE_W-1:0] handle);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap        = $urandom_range(0, 12);
      if (gap > 0) begin
        @(negedge clk_i);
        in_valid_i = 1'b0;
        in_data_i  = IN_W'({$urandom, $urandom});
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    @(negedge clk_i);
    in_valid_i         = 1'b1;
    in_data_i.mode     = mode;
    in_data_i.key_char = ch;
    in_data_i.key_last = last;
    in_data_i.handle   = handle;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    burst_left--;
    chars_sent++;
  endtask

  task automatic send_key(input key_t k, input logic mode, input logic [HANDLE_W-1:0] handle);
    for (int i = 0; i < k.len; i++) begin
      if (i == k.len - 1) send_char(mode, k.chars[i], 1'b1, handle);
      else send_char(1'($urandom), k.chars[i], 1'b0, $urandom);
    end
  endtask

  // hold off until every lookup has returned and the block has gone quiet
  task automatic settle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_count != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_size(input logic [CFG_W-1:0] size);
    settle();
    cfg_we_i    = 1'b1;
    cfg_wdata_i = size;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
  endtask

  function automatic key_t random_key();
    key_t k;
    k.len = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(4, MAX_KEY_LEN))
                                        : 3'($urandom_range(1, 3));
    for (int i = 0; i < MAX_KEY_LEN; i++) k.chars[i] = 8'($urandom_range(0, 255));
    return k;
  endfunction

  initial begin
    key_t             k;
    logic [CFG_W-1:0] size;
    logic             mode;
    int               n_keys;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_char(MODE_INSERT, 8'h00, 1'b1, 32'h0000_0000);
    send_char(MODE_FIND,   8'h00, 1'b1, $urandom);
    send_char(MODE_FIND,   8'hFF, 1'b1, 32'hFFFF_FFFF);
    send_char(MODE_INSERT, 8'hFF, 1'b1, 32'hFFFF_FFFF);
    send_char(MODE_FIND,   8'hFF, 1'b1, 32'h0000_0000);
    k.len   = 3'd3;
    k.chars = {8'h00, 8'h00, 8'h00, 8'h63, 8'h62, 8'h61};
    send_key(k, MODE_INSERT, 32'hA5A5_5A5A);
    send_key(k, MODE_FIND,   $urandom);
    send_key(k, MODE_INSERT, 32'h1234_5678);
    write_size(9'd1);
    send_char(MODE_INSERT, 8'h78, 1'b0, $urandom);
    send_char(MODE_INSERT, 8'h79, 1'b1, 32'h0BAD_F00D);
    send_char(MODE_FIND,   8'h71, 1'b1, $urandom);
    write_size(9'd0);
    send_char(MODE_FIND,   8'h7A, 1'b1, $urandom);
    write_size(9'd511);
    send_char(MODE_FIND,   8'hFF, 1'b1, $urandom);
    send_char(MODE_FIND,   8'h41, 1'b0, $urandom);
    write_size(9'd7);
    send_char(MODE_INSERT, 8'h42, 1'b1, $urandom);
    write_size(9'd257);
    send_char(MODE_FIND,   8'h00, 1'b1, $urandom);

    while (chars_sent < ITEM_TARGET) begin
      case ($urandom_range(0, 9))
        0: size = 9'd0;
        1: size = 9'd1;
        2: size = 9'd256;
        3: size = 9'd511;
        4: size = CFG_W'($urandom_range(2, 256));
        5: size = CFG_W'($urandom_range(257, 511));
        default: size = CFG_W'($urandom_range(2, 16));
      endcase
      write_size(size);
      key_pool.delete();
      n_keys = $urandom_range(10, 40);
      repeat (n_keys) begin
        if (key_pool.size() != 0 && $urandom_range(0, 99) < 50) begin
          k = key_pool[$urandom_range(0, key_pool.size() - 1)];
        end else begin
          k = random_key();
          if (key_pool.size() < 12) key_pool.push_back(k);
        end
        mode = ($urandom_range(0, 99) < 45) ? MODE_INSERT : MODE_FIND;
        send_key(k, mode, $urandom);
      end
      // leave a key half sent so the next size applies mid key
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 2)) send_char(1'($urandom), 8'($urandom_range(0, 255)),
                                                 1'b0, $urandom);
    end

    settle();
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

/* files.f */
hw/rtl/shdm_pkg.sv
hw/rtl/shdm_rem_unit.sv
hw/rtl/string_hashed_direct_map.sv
tb/shdm_result_checker.sv
tb/tb_string_hashed_direct_map.sv
